/* hdl/gtetg_pkg.sv */
// ----------------------------------------------------------------------------
// gtetg_pkg: shared types and constants of the frame-time governor
// widths, register indexes, reset values and the front/back job struct
// ----------------------------------------------------------------------------
`default_nettype none

package gtetg_pkg;

  localparam int unsigned TICK_W     = 64;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // delta * 1000 fits in 74 bits, then 16 fraction bits below
  localparam int unsigned PROD_W   = TICK_W + 10;
  localparam int unsigned DVD_W    = PROD_W + 16;
  localparam int unsigned STEP_W   = $clog2(DVD_W);
  localparam int unsigned BLEND_W  = MS_W + WEIGHT_W;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RAISE_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = CFG_IDX_W'(2);

  // register reset values
  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST    = WEIGHT_W'(9830);
  localparam logic [MS_W-1:0]     RAISE_THRESHOLD_RST = MS_W'(229376);
  localparam logic [MS_W-1:0]     LOWER_THRESHOLD_RST = MS_W'(170394);

  typedef struct packed {
    logic [WEIGHT_W-1:0] blend_weight;
    logic [MS_W-1:0]     raise_threshold;
    logic [MS_W-1:0]     lower_threshold;
  } gtetg_cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic              ok;
    logic [TICK_W-1:0] delta;
    logic [TICK_W-1:0] rate;
  } gtetg_job_t;

  typedef struct packed {
    logic            sample_taken;
    logic [MS_W-1:0] sample_ms;
    logic [MS_W-1:0] average_ms;
    logic            quality_tier;
  } gtetg_res_t;

endpackage

`default_nettype wire

/* hdl/gtetg_sample_if.sv */
// ----------------------------------------------------------------------------
// gtetg_sample_if: timestamp sample channel
// valid/ready handshake carrying one timed piece of work
// ----------------------------------------------------------------------------
`default_nettype none

interface gtetg_sample_if import gtetg_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] begin_ticks;
  logic [TICK_W-1:0] end_ticks;
  logic [TICK_W-1:0] tick_rate;
  logic              discontinuous;

  modport source (
    output valid, begin_ticks, end_ticks, tick_rate, discontinuous,
    input  ready
  );

  modport sink (
    input  valid, begin_ticks, end_ticks, tick_rate, discontinuous,
    output ready
  );

endinterface

`default_nettype wire

/* hdl/gtetg_result_if.sv */
// ----------------------------------------------------------------------------
// gtetg_result_if: governor result channel
// valid/ready handshake carrying sample, average and tier
// ----------------------------------------------------------------------------
`default_nettype none

interface gtetg_result_if import gtetg_pkg::*; ();

  logic            valid;
  logic            ready;
  logic            sample_taken;
  logic [MS_W-1:0] sample_ms;
  logic [MS_W-1:0] average_ms;
  logic            quality_tier;

  modport source (
    output valid, sample_taken, sample_ms, average_ms, quality_tier,
    input  ready
  );

  modport sink (
    input  valid, sample_taken, sample_ms, average_ms, quality_tier,
    output ready
  );

endinterface

`default_nettype wire

/* hdl/gpu_time_ema_tier_governor_core.sv */
// ----------------------------------------------------------------------------
// gpu_time_ema_tier_governor_core: frame-time governor top level
// q16.16 ms moving average of timed work with a two-level hysteresis tier
// ----------------------------------------------------------------------------
// usage
//   sample_i carries begin/end timestamps, tick rate and a discontinuity flag;
//   result_o returns exactly one item per sample: taken flag, sample in
//   q16.16 ms (zero when rejected), the average and the quality tier
//   the front classifies and queues samples (QueueDepth entries), so intake
//   carries on while the back end works and while a result waits
//   accepted sample: after leaving the queue it passes setup, the 90-step
//   bit-serial divider (one quotient bit a cycle), saturation, two blend
//   multiplies on one shared 32x17 multiplier (skipped for the sample
//   that seeds the average), the tier step and the hand-off to the output
//   register; the queue registers each sample ahead of that
//   rejected sample: handed to the output register once that is free; the
//   back end is free again once it has handed the item over
//   the back end takes no new sample until its last one is handed over
//   cfg_we_i writes register cfg_idx_i (weight, raise, lower threshold);
//   indexes beyond the list are ignored; write only when idle
//   reset: registers to their defaults, average zero and unseeded, full tier,
//   queue empty, no result pending
//   a stalled result_o holds its item; the back end then waits with its
//   finished item and the queue fills before sample_i drops ready
// ----------------------------------------------------------------------------
`default_nettype none

module gpu_time_ema_tier_governor_core import gtetg_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  gtetg_sample_if.sink               sample_i,
  gtetg_result_if.source             result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  gtetg_cfg_t cfg_q, cfg_d;
  gtetg_job_t job;
  logic       job_valid, job_ready;
  gtetg_res_t res;
  logic       res_valid;

  // configuration registers, values masked to register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLEND_WEIGHT:    cfg_d.blend_weight    = cfg_wdata_i[WEIGHT_W-1:0];
        REG_RAISE_THRESHOLD: cfg_d.raise_threshold = cfg_wdata_i[MS_W-1:0];
        REG_LOWER_THRESHOLD: cfg_d.lower_threshold = cfg_wdata_i[MS_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_weight    <= BLEND_WEIGHT_RST;
      cfg_q.raise_threshold <= RAISE_THRESHOLD_RST;
      cfg_q.lower_threshold <= LOWER_THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // intake and queue
  gtetg_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  // conversion, averaging, tier and output register
  gtetg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (result_o.ready)
  );

  assign result_o.valid        = res_valid;
  assign result_o.sample_taken = res.sample_taken;
  assign result_o.sample_ms    = res.sample_ms;
  assign result_o.average_ms   = res.average_ms;
  assign result_o.quality_tier = res.quality_tier;

endmodule

`default_nettype wire

/* hdl/gtetg_front.sv */
// ----------------------------------------------------------------------------
// gtetg_front: sample intake
// classifies each item, forms the tick delta and queues it for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module gtetg_front import gtetg_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH  // 2 or more
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  gtetg_sample_if.sink    sample_i,
  output gtetg_job_t      job_o,
  output logic            job_valid_o,
  input  wire logic       job_ready_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  gtetg_job_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  gtetg_job_t       job_in;
  logic             push, pop;

  // reject disjoint, zero-rate and non-increasing samples
  always_comb begin
    job_in.ok    = !sample_i.discontinuous && (sample_i.tick_rate != '0) &&
                   (sample_i.end_ticks > sample_i.begin_ticks);
    job_in.delta = sample_i.end_ticks - sample_i.begin_ticks;
    job_in.rate  = sample_i.tick_rate;
  end

  assign sample_i.ready = (count_q != CntW'(Depth));
  assign push           = sample_i.valid && sample_i.ready;
  assign job_valid_o    = (count_q != '0);
  assign pop            = job_valid_o && job_ready_i;
  assign job_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* hdl/gtetg_back.sv */
// ----------------------------------------------------------------------------
// gtetg_back: sample conversion, averaging and tier update
// bit-serial division to q16.16 ms, blend on a shared multiplier, hysteresis
// ----------------------------------------------------------------------------
`default_nettype none

module gtetg_back import gtetg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire gtetg_cfg_t cfg_i,
  input  wire gtetg_job_t job_i,
  input  wire logic       job_valid_i,
  output logic            job_ready_o,
  output gtetg_res_t      res_o,
  output logic            res_valid_o,
  input  wire logic       res_ready_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_SAT    = 3'd3;
  localparam logic [2:0] ST_BLEND0 = 3'd4;
  localparam logic [2:0] ST_BLEND1 = 3'd5;
  localparam logic [2:0] ST_BLEND2 = 3'd6;
  localparam logic [2:0] ST_TIER   = 3'd7;

  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(DVD_W - 1);
  localparam logic [STEP_W-1:0] STEP_INT = STEP_W'(MS_W);

  logic [2:0]         state_q, state_d;
  logic               out_pend_q, out_pend_d;  // item finished, waiting for output reg
  logic               out_valid_q, out_valid_d;
  logic [MS_W-1:0]    avg_q, avg_d;
  logic               seeded_q, seeded_d;
  logic               tier_q, tier_d;

  logic [TICK_W-1:0]  delta_q, delta_d;
  logic [TICK_W-1:0]  rate_q, rate_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [TICK_W-1:0]  rem_q, rem_d;
  logic [MS_W-1:0]    quo_q, quo_d;
  logic               over_q, over_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [MS_W-1:0]    ms_q, ms_d;
  logic               taken_q, taken_d;
  logic [BLEND_W-1:0] prod_q, prod_d;
  logic [BLEND_W-1:0] acc_q, acc_d;
  gtetg_res_t         out_res_q, out_res_d;

  logic [WEIGHT_W-1:0] w_eff, w_inv;
  logic [MS_W-1:0]     mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [BLEND_W-1:0]  mul_p, blend_sum;
  logic [PROD_W-1:0]   delta_ext, scaled;
  logic [TICK_W:0]     rem_sh, rate_ext, rem_diff;
  logic                fits;

  // weight above one counts as one
  assign w_eff = (cfg_i.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_i.blend_weight;
  assign w_inv = WEIGHT_ONE - w_eff;

  // one multiplier shared by both blend terms
  assign mul_a     = (state_q == ST_BLEND0) ? avg_q : ms_q;
  assign mul_b     = (state_q == ST_BLEND0) ? w_inv : w_eff;
  assign mul_p     = BLEND_W'(mul_a) * BLEND_W'(mul_b);
  assign blend_sum = acc_q + prod_q;

  // delta * 1000 as (delta << 10) - (delta << 4) - (delta << 3)
  assign delta_ext = PROD_W'(delta_q);
  assign scaled    = (delta_ext << 10) - (delta_ext << 4) - (delta_ext << 3);

  // restoring division step
  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign rate_ext = {1'b0, rate_q};
  assign fits     = (rem_sh >= rate_ext);
  assign rem_diff = rem_sh - rate_ext;

  assign job_ready_o = (state_q == ST_IDLE) && !out_pend_q;
  assign res_o       = out_res_q;
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_pend_d  = out_pend_q;
    out_valid_d = out_valid_q;
    avg_d       = avg_q;
    seeded_d    = seeded_q;
    tier_d      = tier_q;
    delta_d     = delta_q;
    rate_d      = rate_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    over_d      = over_q;
    step_d      = step_q;
    ms_d        = ms_q;
    taken_d     = taken_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_res_d   = out_res_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i && !out_pend_q) begin
          if (job_i.ok) begin
            delta_d = job_i.delta;
            rate_d  = job_i.rate;
            state_d = ST_MUL;
          end else begin
            taken_d    = 1'b0;
            ms_d       = '0;
            out_pend_d = 1'b1;
          end
        end
      end
      ST_MUL: begin
        dvd_d   = {scaled, 16'h0000};
        rem_d   = '0;
        quo_d   = '0;
        over_d  = 1'b0;
        step_d  = STEP_TOP;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = fits ? rem_diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
        quo_d = {quo_q[MS_W-2:0], fits};
        dvd_d = dvd_q << 1;
        if (fits && (step_q >= STEP_INT)) begin
          over_d = 1'b1;
        end
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        ms_d    = over_q ? '1 : quo_q;
        taken_d = 1'b1;
        if (seeded_q) begin
          state_d = ST_BLEND0;
        end else begin
          avg_d    = over_q ? '1 : quo_q;
          seeded_d = 1'b1;
          state_d  = ST_TIER;
        end
      end
      ST_BLEND0: begin
        prod_d  = mul_p;
        state_d = ST_BLEND1;
      end
      ST_BLEND1: begin
        acc_d   = prod_q;
        prod_d  = mul_p;
        state_d = ST_BLEND2;
      end
      ST_BLEND2: begin
        avg_d   = blend_sum[MS_W+15:16];
        state_d = ST_TIER;
      end
      ST_TIER: begin
        if (!tier_q) begin
          tier_d = (avg_q > cfg_i.raise_threshold);
        end else begin
          tier_d = !(avg_q < cfg_i.lower_threshold);
        end
        out_pend_d = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hand the finished item to the output register once it is free
    if (out_pend_q && (!out_valid_q || res_ready_i)) begin
      out_pend_d             = 1'b0;
      out_valid_d            = 1'b1;
      out_res_d.sample_taken = taken_q;
      out_res_d.sample_ms    = ms_q;
      out_res_d.average_ms   = avg_q;
      out_res_d.quality_tier = tier_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      seeded_q    <= 1'b0;
      tier_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_pend_q  <= out_pend_d;
      out_valid_q <= out_valid_d;
      avg_q       <= avg_d;
      seeded_q    <= seeded_d;
      tier_q      <= tier_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q   <= delta_d;
    rate_q    <= rate_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    over_q    <= over_d;
    step_q    <= step_d;
    ms_q      <= ms_d;
    taken_q   <= taken_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    out_res_q <= out_res_d;
  end

  a_reject_zero_ms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.sample_taken) |-> (out_res_q.sample_ms == '0))
    else $error("rejected item with nonzero sample_ms");

  a_div_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rate_q != '0))
    else $error("division running on zero rate");

  a_tier_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TIER) && !tier_q && (avg_q <= cfg_i.raise_threshold)) |=> !tier_q)
    else $error("tier raised without crossing raise threshold");

  a_tier_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TIER) |=> (tier_q == $past(tier_q)))
    else $error("tier moved outside tier update");

endmodule

`default_nettype wire
